// ===== hdl/rgb_to_hsl_convert_defines.svh =====
// assertion macros for the rgb to hsl converter
`ifndef RGB_TO_HSL_CONVERT_DEFINES_SVH
`define RGB_TO_HSL_CONVERT_DEFINES_SVH

// check that a condition implies a consequence on the same edge
`define RTH_ASSERT_IMPLY(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// check that a condition implies a consequence after a fixed delay
`define RTH_ASSERT_DELAY(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) \
      (cond) |-> ##(rgb_to_hsl_pkg::NUM_CELLS) (cons)) else $error("assertion failed");

`endif

// ===== hdl/rgb_to_hsl_pkg.sv =====
// shared types and constants of the rgb to hsl converter
package rgb_to_hsl_pkg;

   localparam int CH_W    = 8;
   localparam int HUE_W   = 15;
   localparam int FRAC_W  = 16;
   localparam int WORK_W  = 24;
   localparam int NUM_CELLS = WORK_W;
   localparam int HUE_LIMIT = 23040;

   // one division lane: partial remainder, dividend shifting out, quotient shifting in
   typedef struct packed {
      logic [CH_W-1:0]   rem;
      logic [WORK_W-1:0] work;
      logic [CH_W-1:0]   div;
   } lane_type;

   // what one cell hands to the next
   typedef struct packed {
      logic              valid;
      lane_type          hue;
      lane_type          sat;
      logic [FRAC_W-1:0] light;
   } stage_type;

endpackage

// ===== hdl/rgb_to_hsl_front.sv =====
// max, min, chroma and division operands of one pixel
module rgb_to_hsl_front (
   input  logic                          valid,
   input  logic [rgb_to_hsl_pkg::CH_W-1:0] blue,
   input  logic [rgb_to_hsl_pkg::CH_W-1:0] green,
   input  logic [rgb_to_hsl_pkg::CH_W-1:0] red,
   output rgb_to_hsl_pkg::stage_type     stage
);
   logic [7:0]         mx, mn, chroma, den;
   logic [8:0]         sum;
   logic signed [19:0] num;
   logic signed [19:0] diff;
   logic [17:0]        light_full;
   logic [23:0]        sat_num;

   // channel extremes
   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
   end

   assign chroma = mx - mn;
   assign sum    = {1'b0, mx} + {1'b0, mn};
   assign den    = (sum > 9'd255) ? 8'(9'd510 - sum) : sum[7:0];

   // hue numerator in degrees times chroma, sector offset included
   always_comb begin
      if (mx == red) begin
         diff = 20'(signed'({1'b0, green})) - 20'(signed'({1'b0, blue}));
         num  = 20'sd60 * diff;
         if (num < 0) num = num + 20'sd360 * 20'(signed'({1'b0, chroma}));
      end else if (mx == green) begin
         diff = 20'(signed'({1'b0, blue})) - 20'(signed'({1'b0, red}));
         num  = 20'sd120 * 20'(signed'({1'b0, chroma})) + 20'sd60 * diff;
      end else begin
         diff = 20'(signed'({1'b0, red})) - 20'(signed'({1'b0, green}));
         num  = 20'sd240 * 20'(signed'({1'b0, chroma})) + 20'sd60 * diff;
      end
   end

   // lightness: sum * 65535 / 510 equals sum * 257 / 2
   assign light_full = 18'({sum, 8'd0}) + 18'(sum);
   assign sat_num    = {chroma, 16'd0} - 24'(chroma);

   // grey pixels divide zero by one so both quotients come out zero
   always_comb begin
      stage.valid    = valid;
      stage.light    = light_full[16:1];
      stage.hue.rem  = '0;
      stage.sat.rem  = '0;
      if (chroma == 8'd0) begin
         stage.hue.work = '0;
         stage.hue.div  = 8'd1;
         stage.sat.work = '0;
         stage.sat.div  = 8'd1;
      end else begin
         stage.hue.work = {1'b0, num[16:0], 6'd0};
         stage.hue.div  = chroma;
         stage.sat.work = sat_num;
         stage.sat.div  = den;
      end
   end
endmodule

// ===== hdl/rgb_to_hsl_cell.sv =====
// one restoring division step for both lanes, registered
module rgb_to_hsl_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  rgb_to_hsl_pkg::stage_type stage_in,
   output rgb_to_hsl_pkg::stage_type stage_out
);
   rgb_to_hsl_pkg::stage_type stage_ff, stage_nx_in;

   function automatic rgb_to_hsl_pkg::lane_type div_step(input rgb_to_hsl_pkg::lane_type l);
      rgb_to_hsl_pkg::lane_type o;
      logic [8:0] r2;
      logic [8:0] diff;
      o    = l;
      r2   = {l.rem, l.work[rgb_to_hsl_pkg::WORK_W-1]};
      diff = r2 - {1'b0, l.div};
      if (r2 >= {1'b0, l.div}) begin
         o.rem  = diff[7:0];
         o.work = {l.work[rgb_to_hsl_pkg::WORK_W-2:0], 1'b1};
      end else begin
         o.rem  = r2[7:0];
         o.work = {l.work[rgb_to_hsl_pkg::WORK_W-2:0], 1'b0};
      end
      return o;
   endfunction

   // next step of each lane
   always_comb begin
      stage_nx_in     = stage_in;
      stage_nx_in.hue = div_step(stage_in.hue);
      stage_nx_in.sat = div_step(stage_in.sat);
   end

   // valid is control, payload needs no reset
   always_ff @(posedge clock) begin
      stage_ff.hue   <= stage_nx_in.hue;
      stage_ff.sat   <= stage_nx_in.sat;
      stage_ff.light <= stage_nx_in.light;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_nx_in.valid;
      end
   end

   assign stage_out = stage_ff;
endmodule

// ===== hdl/rgb_to_hsl_convert.sv =====
// top level of the rgb to hsl converter
// Takes one pixel per clock while busy is low (busy is high only during reset) and
// gives its hue, saturation and lightness at the end of the cell row, one strobe per
// item on rsp_valid. The pixel passes through a row of 24 registered division cells, each of
// which works out one quotient bit of hue and of saturation; results cannot be held off.
`include "rgb_to_hsl_convert_defines.svh"
module rgb_to_hsl_convert (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_red,
   output logic        rsp_valid,
   output logic [14:0] rsp_hue,
   output logic [15:0] rsp_saturation,
   output logic [15:0] rsp_lightness
);
   rgb_to_hsl_pkg::stage_type chain [rgb_to_hsl_pkg::NUM_CELLS+1];
   logic accept;

   assign busy   = reset;
   assign accept = start & ~busy;

   // operand setup
   rgb_to_hsl_front u_front (
      .valid (accept),
      .blue  (req_blue),
      .green (req_green),
      .red   (req_red),
      .stage (chain[0])
   );

   // row of division cells
   for (genvar i = 0; i < rgb_to_hsl_pkg::NUM_CELLS; i++) begin : g_cell
      rgb_to_hsl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   // result ports
   assign rsp_valid      = chain[rgb_to_hsl_pkg::NUM_CELLS].valid;
   assign rsp_hue        = chain[rgb_to_hsl_pkg::NUM_CELLS].hue.work[14:0];
   assign rsp_saturation = chain[rgb_to_hsl_pkg::NUM_CELLS].sat.work[15:0];
   assign rsp_lightness  = chain[rgb_to_hsl_pkg::NUM_CELLS].light;

   // checks
   `RTH_ASSERT_DELAY(a_latency, clock, reset, accept, rsp_valid)
   `RTH_ASSERT_IMPLY(a_hue_range, clock, reset, rsp_valid,
      chain[rgb_to_hsl_pkg::NUM_CELLS].hue.work < 24'(rgb_to_hsl_pkg::HUE_LIMIT))
   `RTH_ASSERT_IMPLY(a_sat_range, clock, reset, rsp_valid,
      chain[rgb_to_hsl_pkg::NUM_CELLS].sat.work[23:16] == 8'd0)
endmodule
